// ===== rtl/assert_macros.svh =====
// Assertion helpers for the mi3 blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rs, ante, cons)
`define ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int KW = 2 * DATA_W + 1;
  localparam int DW = 3 * DATA_W + 3;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [KW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [KW-1:0] mag_t;

  typedef struct packed {
    logic  op;
    elem_t a11;
    elem_t a12;
    elem_t a13;
    elem_t a21;
    elem_t a22;
    elem_t a23;
    elem_t a31;
    elem_t a32;
    elem_t a33;
  } in_word_t;

  typedef struct packed {
    elem_t r11;
    elem_t r12;
    elem_t r13;
    elem_t r21;
    elem_t r22;
    elem_t r23;
    elem_t r31;
    elem_t r32;
    elem_t r33;
    elem_t det_value;
    logic  singular;
  } out_word_t;

  typedef struct packed {
    logic  valid;
    logic  singular;
    elem_t det_value;
  } ctl_t;

  // element indices (row-major) of p*q - r*s for each cofactor
  localparam int CI [9][4] = '{
    '{4, 8, 5, 7}, '{3, 8, 5, 6}, '{3, 7, 4, 6},
    '{1, 8, 2, 7}, '{0, 8, 2, 6}, '{0, 7, 1, 6},
    '{1, 5, 2, 4}, '{0, 5, 2, 3}, '{0, 4, 1, 3}
  };
  localparam int TR [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  function automatic elem_t sat_w(input logic neg, input logic [DATA_W:0] mag);
    logic [DATA_W:0] lim;
    logic [DATA_W:0] m;
    lim = {2'b01, {(DATA_W - 1){1'b0}}};
    if (!neg) lim = lim - (DATA_W + 1)'(1);
    m = (mag > lim) ? lim : mag;
    sat_w = neg ? elem_t'(~m[DATA_W-1:0] + 1'b1) : elem_t'(m[DATA_W-1:0]);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Inverse (op 0) or transposed inverse (op 1) of a 3x3 Q16.16 matrix by the
// adjugate method, with the determinant and a singular flag. busy never
// rises: a word is taken on every cycle that start is high, and each result
// appears on out_word for one cycle with done, after the cofactor, determinant
// and divider pipelines. The receiver cannot hold results off. The divider
// resolves one quotient bit per stage for all nine elements; throughput is one
// matrix per cycle.
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      done,
  output out_word_t out_word
);
  localparam int LAT = DATA_W + 7;

  elem_t a [9];
  logic  cv, cop;
  elem_t row [3];
  cof_t  k [9];
  ctl_t  dctl;
  logic [DW-1:0] dmag;
  mag_t  num [9];
  logic  neg [9];

  assign busy = 1'b0;
  assign a = '{in_word.a11, in_word.a12, in_word.a13,
               in_word.a21, in_word.a22, in_word.a23,
               in_word.a31, in_word.a32, in_word.a33};

  mi3_cofactor u_cof (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_op(in_word.op), .a(a),
    .valid(cv), .op(cop), .row(row), .k(k)
  );

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .rst(rst), .in_valid(cv), .in_op(cop), .row(row), .k(k),
    .ctl(dctl), .dmag(dmag), .num(num), .neg(neg)
  );

  mi3_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .in_ctl(dctl), .dmag(dmag), .num(num), .neg(neg),
    .valid(done), .res(out_word)
  );

  `ASSERT_IMP(a_lat, clk, rst, done, $past(start, LAT))
  `ASSERT_IMP(a_sing_zero, clk, rst, done && out_word.singular, out_word.det_value == '0 && out_word.r11 == '0 && out_word.r22 == '0 && out_word.r33 == '0)
  `ASSERT_IMP(a_det_sing, clk, rst, done && !out_word.singular && out_word.det_value != '0, !out_word.singular)
endmodule
`default_nettype wire

// ===== rtl/mi3_cofactor.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mi3_cofactor import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  input  elem_t a [9],
  output logic  valid,
  output logic  op,
  output elem_t row [3],
  output cof_t  k [9]
);
  logic signed [2*DATA_W-1:0] p [9];
  logic signed [2*DATA_W-1:0] q [9];
  logic  va;
  logic  opa;
  elem_t rowa [3];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_valid;
    opa <= in_op;
    for (int r = 0; r < 3; r++) rowa[r] <= a[r];
    for (int l = 0; l < 9; l++) begin
      p[l] <= a[CI[l][0]] * a[CI[l][1]];
      q[l] <= a[CI[l][2]] * a[CI[l][3]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= va;
    op <= opa;
    row <= rowa;
    // odd cofactors carry the checkerboard minus sign
    for (int l = 0; l < 9; l++) begin
      if (l % 2 == 1) k[l] <= KW'(q[l]) - KW'(p[l]);
      else k[l] <= KW'(p[l]) - KW'(q[l]);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mi3_det.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mi3_det import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  input  elem_t row [3],
  input  cof_t  k [9],
  output ctl_t  ctl,
  output logic [DW-1:0] dmag,
  output mag_t  num [9],
  output logic  neg [9]
);
  logic signed [2*DATA_W:0] plo [3];
  logic signed [2*DATA_W:0] phi [3];
  cof_t kc [9];
  cof_t kd [9];
  logic vc, vd, opc, opd;
  det_t det;
  det_t det_sum;
  logic dneg;
  logic [DW-1:0] dabs;
  logic [DW-1:0] dq;
  logic [DATA_W:0] dqm;
  cof_t csel [9];

  // split each cofactor so a multiply stays near one word square
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= in_valid;
    opc <= in_op;
    kc <= k;
    for (int j = 0; j < 3; j++) begin
      plo[j] <= row[j] * $signed({1'b0, k[j][DATA_W-1:0]});
      phi[j] <= row[j] * $signed(k[j][KW-1:DATA_W]);
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++)
      det_sum = det_sum + (DW'(phi[j]) <<< DATA_W) + DW'(plo[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= vc;
    opd <= opc;
    kd <= kc;
    det <= det_sum;
  end

  always_comb begin
    dneg = det[DW-1];
    dabs = dneg ? DW'(-det) : DW'(det);
    dq = dabs >> (2 * FRAC_BITS);
    dqm = ((dq >> DATA_W) != '0) ? {1'b1, {DATA_W{1'b0}}} : {1'b0, dq[DATA_W-1:0]};
    for (int l = 0; l < 9; l++) csel[l] = opd ? kd[l] : kd[TR[l]];
  end

  always_ff @(posedge clk) begin
    if (rst) ctl.valid <= 1'b0;
    else ctl.valid <= vd;
    ctl.singular <= (det == '0);
    ctl.det_value <= sat_w(dneg, dqm);
    dmag <= dabs;
    for (int l = 0; l < 9; l++) begin
      num[l] <= csel[l][KW-1] ? mag_t'(-csel[l]) : mag_t'(csel[l]);
      neg[l] <= csel[l][KW-1] ^ dneg;
    end
  end

  `ASSERT_IMP(a_dmag_nz, clk, rst, ctl.valid && !ctl.singular, dmag != '0)
endmodule
`default_nettype wire

// ===== rtl/mi3_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mi3_divider import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic      clk,
  input  logic      rst,
  input  ctl_t      in_ctl,
  input  logic [DW-1:0] dmag,
  input  mag_t      num [9],
  input  logic      neg [9],
  output logic      valid,
  output out_word_t res
);
  localparam int CW = DW + DATA_W + 2 * FRAC_BITS;

  logic [CW-1:0]     rem [DATA_W+1][9];
  logic [DATA_W-1:0] qb  [DATA_W+1][9];
  logic              ovf [DATA_W+1][9];
  logic              ng  [DATA_W+1][9];
  logic [CW-1:0]     dv  [DATA_W+1];
  ctl_t              ctl [DATA_W+1];

  // overflow test: a quotient wider than W bits saturates
  always_ff @(posedge clk) begin
    if (rst) ctl[0].valid <= 1'b0;
    else ctl[0] <= in_ctl;
    dv[0] <= CW'(dmag);
    for (int l = 0; l < 9; l++) begin
      rem[0][l] <= CW'(num[l]) << (2 * FRAC_BITS);
      ovf[0][l] <= ((CW'(num[l]) << (2 * FRAC_BITS)) >= (CW'(dmag) << DATA_W));
      ng[0][l]  <= neg[l];
      qb[0][l]  <= '0;
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < DATA_W; s++) begin : g_step
    logic [CW-1:0] dsh;
    assign dsh = dv[s] << (DATA_W - 1 - s);
    always_ff @(posedge clk) begin
      if (rst) ctl[s+1].valid <= 1'b0;
      else ctl[s+1] <= ctl[s];
      dv[s+1] <= dv[s];
      for (int l = 0; l < 9; l++) begin
        ovf[s+1][l] <= ovf[s][l];
        ng[s+1][l]  <= ng[s][l];
        if (rem[s][l] >= dsh) begin
          rem[s+1][l] <= rem[s][l] - dsh;
          qb[s+1][l]  <= qb[s][l] | (DATA_W'(1) << (DATA_W - 1 - s));
        end else begin
          rem[s+1][l] <= rem[s][l];
          qb[s+1][l]  <= qb[s][l];
        end
      end
    end
  end

  elem_t rs [9];
  always_comb begin
    for (int l = 0; l < 9; l++)
      rs[l] = ctl[DATA_W].singular ? '0 :
              sat_w(ng[DATA_W][l],
                    ovf[DATA_W][l] ? {1'b1, {DATA_W{1'b0}}} : {1'b0, qb[DATA_W][l]});
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= ctl[DATA_W].valid;
    res.r11 <= rs[0];
    res.r12 <= rs[1];
    res.r13 <= rs[2];
    res.r21 <= rs[3];
    res.r22 <= rs[4];
    res.r23 <= rs[5];
    res.r31 <= rs[6];
    res.r32 <= rs[7];
    res.r33 <= rs[8];
    res.det_value <= ctl[DATA_W].singular ? '0 : ctl[DATA_W].det_value;
    res.singular <= ctl[DATA_W].singular;
  end
endmodule
`default_nettype wire

// ===== tb/sv/matrix3x3_inverse_checker.sv =====
`timescale 1ns / 1ps
module matrix3x3_inverse_checker import mi3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      done,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);
  localparam int FB = FRAC_W;

  out_word_t inverse_q[$];

  // signed W-bit word from sign and magnitude, clamped to the signed range
  function automatic elem_t clamp_word(input logic neg, input logic [255:0] mag);
    logic [255:0] lim;
    lim = 256'd1 << (DATA_W - 1);
    if (!neg) lim = lim - 256'd1;
    if (mag > lim) mag = lim;
    return neg ? elem_t'(-mag[DATA_W-1:0]) : elem_t'(mag[DATA_W-1:0]);
  endfunction

  function automatic out_word_t predict_inverse(input in_word_t w);
    logic signed [255:0] el [9];
    logic signed [255:0] adj [9];
    logic signed [255:0] det, c;
    logic [255:0] dmag, num, q;
    logic neg;
    out_word_t r;
    el = '{w.a11, w.a12, w.a13, w.a21, w.a22, w.a23, w.a31, w.a32, w.a33};
    adj[0] =   el[4] * el[8] - el[5] * el[7];
    adj[1] = -(el[3] * el[8] - el[5] * el[6]);
    adj[2] =   el[3] * el[7] - el[4] * el[6];
    adj[3] = -(el[1] * el[8] - el[2] * el[7]);
    adj[4] =   el[0] * el[8] - el[2] * el[6];
    adj[5] = -(el[0] * el[7] - el[1] * el[6]);
    adj[6] =   el[1] * el[5] - el[2] * el[4];
    adj[7] = -(el[0] * el[5] - el[2] * el[3]);
    adj[8] =   el[0] * el[4] - el[1] * el[3];
    det = el[0] * adj[0] + el[1] * adj[1] + el[2] * adj[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = det[255] ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // op 0 takes the adjugate (transposed cofactors)
        c = w.op ? adj[i*3+j] : adj[j*3+i];
        neg = c[255] ^ det[255];
        num = (c[255] ? -c : c) << (2 * FB);
        q = num / dmag;
        r[$bits(out_word_t)-1-(i*3+j)*DATA_W -: DATA_W] = clamp_word(neg && q != 0, q);
      end
    end
    q = dmag >> (2 * FB);
    r.det_value = clamp_word(det[255] && q != 0, q);
    return r;
  endfunction

  assign pending = inverse_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) inverse_q.push_back(predict_inverse(in_word));
      if (done) begin
        if (inverse_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = inverse_q.pop_front();
          if (exp_w !== out_word) begin
            if (exp_w.r11 !== out_word.r11) $error("r11 exp %0d got %0d", exp_w.r11, out_word.r11);
            if (exp_w.r12 !== out_word.r12) $error("r12 exp %0d got %0d", exp_w.r12, out_word.r12);
            if (exp_w.r13 !== out_word.r13) $error("r13 exp %0d got %0d", exp_w.r13, out_word.r13);
            if (exp_w.r21 !== out_word.r21) $error("r21 exp %0d got %0d", exp_w.r21, out_word.r21);
            if (exp_w.r22 !== out_word.r22) $error("r22 exp %0d got %0d", exp_w.r22, out_word.r22);
            if (exp_w.r23 !== out_word.r23) $error("r23 exp %0d got %0d", exp_w.r23, out_word.r23);
            if (exp_w.r31 !== out_word.r31) $error("r31 exp %0d got %0d", exp_w.r31, out_word.r31);
            if (exp_w.r32 !== out_word.r32) $error("r32 exp %0d got %0d", exp_w.r32, out_word.r32);
            if (exp_w.r33 !== out_word.r33) $error("r33 exp %0d got %0d", exp_w.r33, out_word.r33);
            if (exp_w.det_value !== out_word.det_value)
              $error("det_value exp %0d got %0d", exp_w.det_value, out_word.det_value);
            if (exp_w.singular !== out_word.singular)
              $error("singular exp %0b got %0b", exp_w.singular, out_word.singular);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/matrix3x3_inverse_tb.sv =====
`timescale 1ns / 1ps
module matrix3x3_inverse_tb import mi3_pkg::*;;
  localparam int LATENCY = DATA_W + 7;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  in_word_t in_word = '0;
  out_word_t out_word;
  int fail_count, pending;
  int cycles = 0;
  int idle_pct = 0;

  matrix3x3_inverse dut (.*);

  matrix3x3_inverse_checker chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return elem_t'($urandom_range(0, 6)) - 3;
      2, 3: return elem_t'(signed'($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      4: return elem_t'(signed'($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // hold the word until it is taken, idling at random beforehand
  task automatic send_matrix(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    in_word_t w;
    logic [31:0] e [9];
    for (int k = 0; k < n; k++) begin
      w.op = 1'($urandom_range(0, 1));
      foreach (e[i]) e[i] = rand_elem();
      // now and then make a row repeat or a row zero to reach singular cases
      case ($urandom_range(0, 9))
        0: begin e[6] = e[0]; e[7] = e[1]; e[8] = e[2]; end
        1: begin e[3] = 0; e[4] = 0; e[5] = 0; end
        default: ;
      endcase
      {w.a11, w.a12, w.a13, w.a21, w.a22, w.a23, w.a31, w.a32, w.a33} =
        {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      send_matrix(w);
    end
  endtask

  task automatic send_directed();
    in_word_t w;
    elem_t one = 32'sh10000;
    for (int o = 0; o < 2; o++) begin
      w = '{o, one, 0, 0, 0, one, 0, 0, 0, one};                     send_matrix(w);
      w = '{o, 2 * one, one, 0, 0, 3 * one, one, one, 0, one};       send_matrix(w);
      w = '{o, one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
            7 * one, 8 * one, 9 * one};                              send_matrix(w);
      w = '{o, 1, 0, 0, 0, 1, 0, 0, 0, 1};                           send_matrix(w);
      w = '{o, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff};
      send_matrix(w);
      w = '{o, 32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
      send_matrix(w);
      w = '{o, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
      send_matrix(w);
      w = '{o, -one, 3, 0, 5, -one, 0, 0, 7, -one};                  send_matrix(w);
      w = '0; w.op = o;                                              send_matrix(w);
      w = '{o, -1, -1, -1, -1, -1, -1, -1, -1, -1};                  send_matrix(w);
      w = '{o, 0, one, 0, one, 0, 0, 0, 0, -one};                    send_matrix(w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 0;
    send_directed();
    idle_pct = 32;
    send_random(280);
    idle_pct = 46;
    send_random(280);
    idle_pct = 0;
    send_random(270);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
